[design/pes_pkg.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pes_pkg
// Shared types and codes for the packed element store.
// ----------------------------------------------------------------------------
package pes_pkg;

    localparam int KIND_W    = 2;
    localparam int IDX_W     = 10;
    localparam int VAL_W     = 5;
    localparam int ST_W      = 2;
    localparam int LEN_W     = 11;
    localparam int WORD_BITS = 16;
    localparam int BOFF_W    = 4;

    // request kinds
    localparam logic [KIND_W-1:0] KIND_READ   = 2'd0;
    localparam logic [KIND_W-1:0] KIND_WRITE  = 2'd1;
    localparam logic [KIND_W-1:0] KIND_APPEND = 2'd2;

    // result status codes
    localparam logic [ST_W-1:0] ST_DONE  = 2'd0;
    localparam logic [ST_W-1:0] ST_RANGE = 2'd1;
    localparam logic [ST_W-1:0] ST_FULL  = 2'd2;

    typedef struct packed {
        logic [KIND_W-1:0] kind;
        logic [IDX_W-1:0]  elem_index;
        logic [VAL_W-1:0]  elem_value;
    } in_t;

    typedef struct packed {
        logic [VAL_W-1:0] read_value;
        logic [ST_W-1:0]  status;
        logic [LEN_W-1:0] length;
    } out_t;

endpackage

[design/pes_bank.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pes_bank
// One bank of word storage: one write port, one read port, registered read.
// ----------------------------------------------------------------------------
module pes_bank #(
    parameter int DEPTH = 161,
    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic                           clk,
    input  logic                           we,
    input  logic [AW-1:0]                  waddr,
    input  logic [pes_pkg::WORD_BITS-1:0]  wdata,
    input  logic                           re,
    input  logic [AW-1:0]                  raddr,
    output logic [pes_pkg::WORD_BITS-1:0]  rdata
);
    import pes_pkg::*;

    logic [WORD_BITS-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
    end

    always_ff @(posedge clk)
    begin
        if (re)
        begin
            rdata <= mem[raddr];
        end
    end

endmodule

[design/pes_lane.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pes_lane
// Extracts and inserts one element in a pair of adjacent 16-bit words.
// ----------------------------------------------------------------------------
module pes_lane #(
    parameter int ELEM_BITS = 5
) (
    input  logic [pes_pkg::WORD_BITS-1:0] lo_word,
    input  logic [pes_pkg::WORD_BITS-1:0] hi_word,
    input  logic [pes_pkg::BOFF_W-1:0]    bit_off,
    input  logic [ELEM_BITS-1:0]          wr_value,
    output logic [ELEM_BITS-1:0]          elem,
    output logic [pes_pkg::WORD_BITS-1:0] new_lo,
    output logic [pes_pkg::WORD_BITS-1:0] new_hi
);
    import pes_pkg::*;

    localparam int PAIR_W = 2 * WORD_BITS;
    localparam logic [PAIR_W-1:0] ELEM_MASK = PAIR_W'((64'd1 << ELEM_BITS) - 64'd1);

    logic [PAIR_W-1:0] pair;
    logic [PAIR_W-1:0] field;
    logic [PAIR_W-1:0] merged;

    always_comb
    begin
        pair   = {hi_word, lo_word};
        field  = pair >> bit_off;
        elem   = field[ELEM_BITS-1:0];
        merged = (pair & ~(ELEM_MASK << bit_off)) | (PAIR_W'(wr_value) << bit_off);
        new_lo = merged[WORD_BITS-1:0];
        new_hi = merged[PAIR_W-1:WORD_BITS];
    end

endmodule

[design/packed_element_store.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// packed_element_store
// Fixed-capacity packed array of ELEM_BITS-wide elements in 16-bit words.
// ----------------------------------------------------------------------------
// Usage:
//   in channel  (in_valid/in_ready/in_data): one request per transaction -
//     read at index, overwrite at index, or append at the current length.
//   out channel (out_valid/out_ready/out_data): exactly one result per request
//     carrying read value, status and the length after the request.
//   Words live in two banks (even and odd word addresses), so the two words
//   an element can straddle are read together and written back together.
//   Each request goes through a bank read at acceptance, then extract/insert
//   and write-back in the access state once the output register is free,
//   which also loads the result register. The block takes no new request
//   until the write-back of the current one is done.
//   After reset the banks are swept to zero, one row of both banks per cycle,
//   over all WORD_COUNT/2+1 rows (161 at the default sizes); in_ready stays
//   low during that sweep.
//   A new request is accepted while a result waits in the output register;
//   if out_ready stays low, the following request holds in its write-back
//   step until the waiting result is taken.
// ----------------------------------------------------------------------------
module packed_element_store #(
    parameter int ELEM_BITS = 5,
    parameter int CAPACITY  = 1024
) (
    input  logic           clk,
    input  logic           rst_n,
    input  logic           in_valid,
    output logic           in_ready,
    input  pes_pkg::in_t   in_data,
    output logic           out_valid,
    input  logic           out_ready,
    output pes_pkg::out_t  out_data
);
    import pes_pkg::*;

    localparam int WORD_COUNT = (CAPACITY * ELEM_BITS + 15) / 16;
    localparam int ROWS       = WORD_COUNT / 2 + 1;
    localparam int ROW_W      = (ROWS > 1) ? $clog2(ROWS) : 1;
    localparam int CNT_W      = $clog2(CAPACITY + 1);
    localparam int POS_W      = CNT_W + 3;
    localparam int WORD_W     = POS_W - BOFF_W;

    typedef enum logic [2:0] {
        S_CLEAR  = 3'b001,
        S_IDLE   = 3'b010,
        S_ACCESS = 3'b100
    } state_t;

    state_t state_reg, state_next;

    logic [ROW_W-1:0]     clr_row_reg, clr_row_next;
    logic [CNT_W-1:0]     count_reg, count_next;
    logic                 out_valid_reg, out_valid_next;
    out_t                 out_data_reg, out_data_next;

    // request context captured at acceptance
    logic                 rd_reg, wr_reg, app_reg;
    logic [ST_W-1:0]      status_reg;
    logic [BOFF_W-1:0]    boff_reg;
    logic                 odd_start_reg;
    logic                 hi_ok_reg;
    logic [ROW_W-1:0]     even_addr_reg, odd_addr_reg;
    logic [ELEM_BITS-1:0] val_reg;

    // acceptance-side decode
    logic                 accept;
    logic                 rd_c, wr_c, app_c;
    logic [ST_W-1:0]      status_c;
    logic [CNT_W-1:0]     tgt_c;
    logic [POS_W-1:0]     pos_c;
    logic [WORD_W-1:0]    word_c;
    logic [ROW_W-1:0]     row_c;
    logic [ROW_W-1:0]     even_addr_c;
    logic                 hi_ok_c;

    // write-back side
    logic                 go;
    logic                 clearing;
    logic [WORD_BITS-1:0] even_q, odd_q;
    logic [WORD_BITS-1:0] lo_word, hi_word;
    logic [WORD_BITS-1:0] new_lo, new_hi;
    logic [ELEM_BITS-1:0] elem;
    logic                 even_we, odd_we;
    logic [ROW_W-1:0]     even_waddr, odd_waddr;
    logic [WORD_BITS-1:0] even_wdata, odd_wdata;

    assign clearing  = (state_reg == S_CLEAR);
    assign in_ready  = (state_reg == S_IDLE);
    assign accept    = in_valid && in_ready;
    assign go        = (state_reg == S_ACCESS) && (!out_valid_reg || out_ready);
    assign out_valid = out_valid_reg;
    assign out_data  = out_data_reg;

    always_comb
    begin
        rd_c     = 1'b0;
        wr_c     = 1'b0;
        app_c    = 1'b0;
        status_c = ST_DONE;
        tgt_c    = '0;
        case (in_data.kind)
            KIND_READ, KIND_WRITE:
            begin
                if (32'(in_data.elem_index) >= 32'(CAPACITY))
                begin
                    status_c = ST_RANGE;
                end
                else
                begin
                    tgt_c = CNT_W'(in_data.elem_index);
                    rd_c  = (in_data.kind == KIND_READ);
                    wr_c  = (in_data.kind == KIND_WRITE);
                end
            end
            KIND_APPEND:
            begin
                if (32'(count_reg) >= 32'(CAPACITY))
                begin
                    status_c = ST_FULL;
                end
                else
                begin
                    tgt_c = count_reg;
                    wr_c  = 1'b1;
                    app_c = 1'b1;
                end
            end
            default:
            begin
                status_c = ST_DONE;
            end
        endcase

        pos_c       = POS_W'(tgt_c) * POS_W'(ELEM_BITS);
        word_c      = pos_c[POS_W-1:BOFF_W];
        row_c       = ROW_W'(word_c >> 1);
        // element starting in an odd word spills into the next even row
        even_addr_c = word_c[0] ? ROW_W'(row_c + 1'b1) : row_c;
        hi_ok_c     = (32'(word_c) + 32'd1) < 32'(WORD_COUNT);
    end

    pes_bank #(.DEPTH(ROWS)) u_even_bank (
        .clk   (clk),
        .we    (even_we),
        .waddr (even_waddr),
        .wdata (even_wdata),
        .re    (accept),
        .raddr (even_addr_c),
        .rdata (even_q)
    );

    pes_bank #(.DEPTH(ROWS)) u_odd_bank (
        .clk   (clk),
        .we    (odd_we),
        .waddr (odd_waddr),
        .wdata (odd_wdata),
        .re    (accept),
        .raddr (row_c),
        .rdata (odd_q)
    );

    always_comb
    begin
        lo_word = odd_start_reg ? odd_q : even_q;
        hi_word = '0;
        if (hi_ok_reg)
        begin
            hi_word = odd_start_reg ? even_q : odd_q;
        end
    end

    pes_lane #(.ELEM_BITS(ELEM_BITS)) u_lane (
        .lo_word  (lo_word),
        .hi_word  (hi_word),
        .bit_off  (boff_reg),
        .wr_value (val_reg),
        .elem     (elem),
        .new_lo   (new_lo),
        .new_hi   (new_hi)
    );

    always_comb
    begin
        if (clearing)
        begin
            even_we    = 1'b1;
            odd_we     = 1'b1;
            even_waddr = clr_row_reg;
            odd_waddr  = clr_row_reg;
            even_wdata = '0;
            odd_wdata  = '0;
        end
        else
        begin
            even_we    = go && wr_reg && (!odd_start_reg || hi_ok_reg);
            odd_we     = go && wr_reg && (odd_start_reg || hi_ok_reg);
            even_waddr = even_addr_reg;
            odd_waddr  = odd_addr_reg;
            even_wdata = odd_start_reg ? new_hi : new_lo;
            odd_wdata  = odd_start_reg ? new_lo : new_hi;
        end
    end

    always_comb
    begin
        state_next     = state_reg;
        clr_row_next   = clr_row_reg;
        count_next     = count_reg;
        out_valid_next = out_valid_reg;
        out_data_next  = out_data_reg;

        if (out_valid_reg && out_ready)
        begin
            out_valid_next = 1'b0;
        end

        case (state_reg)
            S_CLEAR:
            begin
                clr_row_next = ROW_W'(clr_row_reg + 1'b1);
                if (clr_row_reg == ROW_W'(ROWS - 1))
                begin
                    state_next = S_IDLE;
                end
            end
            S_IDLE:
            begin
                if (accept)
                begin
                    state_next = S_ACCESS;
                end
            end
            S_ACCESS:
            begin
                if (go)
                begin
                    count_next               = CNT_W'(count_reg + CNT_W'(app_reg));
                    out_valid_next           = 1'b1;
                    out_data_next.read_value = rd_reg ? VAL_W'(elem) : '0;
                    out_data_next.status     = status_reg;
                    out_data_next.length     = LEN_W'(count_next);
                    state_next               = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_CLEAR;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_CLEAR;
            clr_row_reg   <= '0;
            count_reg     <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            clr_row_reg   <= clr_row_next;
            count_reg     <= count_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        out_data_reg <= out_data_next;
        if (accept)
        begin
            rd_reg        <= rd_c;
            wr_reg        <= wr_c;
            app_reg       <= app_c;
            status_reg    <= status_c;
            boff_reg      <= pos_c[BOFF_W-1:0];
            odd_start_reg <= word_c[0];
            hi_ok_reg     <= hi_ok_c;
            even_addr_reg <= even_addr_c;
            odd_addr_reg  <= row_c;
            val_reg       <= ELEM_BITS'(in_data.elem_value);
        end
    end

endmodule

[dv/pes_result_checker.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pes_result_checker
// Watches both channels of the packed element store. Every request taken in
// updates a private copy of the word store and the element count, and the
// result it should produce is queued. Every result taken out is compared
// field by field with the oldest queued result.
// ----------------------------------------------------------------------------
module pes_result_checker #(
    parameter int ELEM_BITS = 5,
    parameter int CAPACITY  = 1024
) (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          in_valid,
    input  logic          in_ready,
    input  pes_pkg::in_t  in_data,
    input  logic          out_valid,
    input  logic          out_ready,
    input  pes_pkg::out_t out_data,
    output int            fail_count,
    output int            pending
);
    import pes_pkg::*;

    localparam int WORD_COUNT = (CAPACITY * ELEM_BITS + WORD_BITS - 1) / WORD_BITS;
    localparam logic [31:0] ELEM_MASK = (32'd1 << ELEM_BITS) - 32'd1;

    logic [WORD_BITS-1:0] store_words [WORD_COUNT];
    int unsigned          elem_count;
    out_t                 expected_results [$];

    // two adjacent words as one 32-bit window; words past the end read as zero
    function automatic logic [31:0] word_pair(int unsigned w);
        logic [31:0] pair;
        pair = '0;
        if (w < WORD_COUNT)
            pair[15:0] = store_words[w];
        if (w + 1 < WORD_COUNT)
            pair[31:16] = store_words[w + 1];
        return pair;
    endfunction

    // applies one request to the local store and returns the result it causes
    function automatic out_t predict_request(in_t req);
        out_t        res;
        int unsigned slot;
        int unsigned pos;
        int unsigned w;
        int unsigned b;
        logic [31:0] pair;
        logic        do_read;
        logic        do_write;
        res      = '0;
        slot     = req.elem_index;
        do_read  = 1'b0;
        do_write = 1'b0;
        case (req.kind)
            KIND_READ, KIND_WRITE:
            begin
                if (req.elem_index >= CAPACITY)
                    res.status = ST_RANGE;
                else if (req.kind == KIND_READ)
                    do_read = 1'b1;
                else
                    do_write = 1'b1;
            end
            KIND_APPEND:
            begin
                if (elem_count >= CAPACITY)
                    res.status = ST_FULL;
                else
                begin
                    slot = elem_count;
                    do_write = 1'b1;
                    elem_count++;
                end
            end
            default:
                ;
        endcase
        pos  = slot * ELEM_BITS;
        w    = pos / WORD_BITS;
        b    = pos % WORD_BITS;
        pair = word_pair(w);
        if (do_read)
            res.read_value = VAL_W'((pair >> b) & ELEM_MASK);
        if (do_write)
        begin
            pair = (pair & ~(ELEM_MASK << b)) | ((32'(req.elem_value) & ELEM_MASK) << b);
            if (w < WORD_COUNT)
                store_words[w] = pair[15:0];
            if (w + 1 < WORD_COUNT)
                store_words[w + 1] = pair[31:16];
        end
        res.length = LEN_W'(elem_count);
        return res;
    endfunction

    function automatic void check_field(string name, int unsigned want, int unsigned got);
        if (want != got)
        begin
            $display("%t: %s mismatch: expected %0d, actual %0d", $time, name, want, got);
            fail_count++;
        end
    endfunction

    always @(posedge clk or negedge rst_n)
    begin
        out_t want;
        if (!rst_n)
        begin
            for (int i = 0; i < WORD_COUNT; i++)
                store_words[i] = '0;
            elem_count = 0;
            expected_results.delete();
            fail_count = 0;
        end
        else
        begin
            if (out_valid && out_ready)
            begin
                if (expected_results.size() == 0)
                begin
                    $display("%t: unexpected result: expected none, actual %0d/%0d/%0d",
                             $time, out_data.read_value, out_data.status, out_data.length);
                    fail_count++;
                end
                else
                begin
                    want = expected_results.pop_front();
                    check_field("read_value", want.read_value, out_data.read_value);
                    check_field("status", want.status, out_data.status);
                    check_field("length", want.length, out_data.length);
                end
            end
            if (in_valid && in_ready)
                expected_results.push_back(predict_request(in_data));
        end
        pending = expected_results.size();
    end

endmodule

[dv/packed_element_store_tb.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// packed_element_store_tb
// Drives the packed element store with a short directed sequence (straddling
// elements, last index, unused kind, reads past the length), then random
// requests weighted toward appends until the store fills and appends are
// refused. Sender gaps and receiver stalls change phase every PHASE_LEN (150)
// transactions; the checker beside the block does all result checking.
// ----------------------------------------------------------------------------
module packed_element_store_tb;
    import pes_pkg::*;

    localparam int ELEM_BITS    = 5;
    localparam int CAPACITY     = 1024;
    localparam int RANDOM_ITEMS = 1150;
    localparam int PHASE_LEN    = 150;
    localparam int TAIL_REFUSED = 20;
    localparam int CYCLE_LIMIT  = 200000;

    localparam logic [IDX_W-1:0] MAX_INDEX = '1;
    localparam logic [VAL_W-1:0] MAX_VALUE = '1;

    localparam logic [KIND_W-1:0] KIND_UNUSED = 2'd3;

    logic        clk       = 1'b0;
    logic        rst_n     = 1'b0;
    logic        in_valid  = 1'b0;
    logic        in_ready;
    in_t         in_data   = '0;
    logic        out_valid;
    logic        out_ready = 1'b0;
    out_t        out_data;

    int          fail_count;
    int          pending;
    int          send_idle_pct = 0;
    int          stall_pct     = 0;
    int          appends_sent  = 0;
    int unsigned cycle_count   = 0;

    always
    begin
        #4 clk = 1'b1;
        #4 clk = 1'b0;
    end

    packed_element_store #(
        .ELEM_BITS (ELEM_BITS),
        .CAPACITY  (CAPACITY)
    ) i_dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .in_data   (in_data),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .out_data  (out_data)
    );

    pes_result_checker #(
        .ELEM_BITS (ELEM_BITS),
        .CAPACITY  (CAPACITY)
    ) i_checker (
        .clk        (clk),
        .rst_n      (rst_n),
        .in_valid   (in_valid),
        .in_ready   (in_ready),
        .in_data    (in_data),
        .out_valid  (out_valid),
        .out_ready  (out_ready),
        .out_data   (out_data),
        .fail_count (fail_count),
        .pending    (pending)
    );

    always @(negedge clk)
        out_ready <= (stall_pct == 0) || ($urandom_range(0, 99) >= stall_pct);

    always @(posedge clk)
    begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT)
        begin
            $display("tb: failure");
            $finish;
        end
    end

    task automatic send_request(input logic [KIND_W-1:0] kind,
                                input logic [IDX_W-1:0]  idx,
                                input logic [VAL_W-1:0]  val);
        @(negedge clk);
        while (send_idle_pct != 0 && $urandom_range(0, 99) < send_idle_pct)
        begin
            in_valid <= 1'b0;
            @(negedge clk);
        end
        in_valid <= 1'b1;
        in_data  <= '{kind: kind, elem_index: idx, elem_value: val};
        if (kind == KIND_APPEND)
            appends_sent++;
        do
            @(posedge clk);
        while (!in_ready);
    endtask

    // hold off the sender until every queued result has come back
    task automatic wait_drained();
        @(negedge clk);
        in_valid <= 1'b0;
        while (pending != 0)
            @(negedge clk);
    endtask

    initial
    begin
        int                n;
        int                r;
        int                filled;
        logic [KIND_W-1:0] kind;
        logic [IDX_W-1:0]  idx;

        repeat (12) @(negedge clk);
        rst_n <= 1'b1;

        // fresh store reads back zero, at both ends
        send_request(KIND_READ, 0, MAX_VALUE);
        send_request(KIND_READ, MAX_INDEX, 0);
        // element 3 straddles words 0 and 1
        send_request(KIND_APPEND, MAX_INDEX, MAX_VALUE);
        send_request(KIND_APPEND, 0, 0);
        send_request(KIND_APPEND, 0, 5'b10101);
        send_request(KIND_APPEND, 0, 5'b01010);
        send_request(KIND_READ, 3, 0);
        send_request(KIND_WRITE, 3, MAX_VALUE);
        send_request(KIND_READ, 2, 0);
        send_request(KIND_READ, 3, 0);
        send_request(KIND_READ, 4, 0);
        // last element sits at the very top of the last word
        send_request(KIND_WRITE, MAX_INDEX, MAX_VALUE);
        send_request(KIND_READ, MAX_INDEX, 0);
        send_request(KIND_WRITE, MAX_INDEX, 0);
        send_request(KIND_READ, MAX_INDEX, MAX_VALUE);
        // past the length but within capacity
        send_request(KIND_WRITE, 600, 17);
        send_request(KIND_READ, 600, 0);
        send_request(KIND_UNUSED, MAX_INDEX, MAX_VALUE);
        send_request(KIND_UNUSED, 0, 0);
        send_request(KIND_WRITE, 0, 0);
        send_request(KIND_READ, 0, MAX_VALUE);
        send_request(KIND_APPEND, 0, MAX_VALUE);
        send_request(KIND_READ, 4, 0);

        // random part: keeps going past the item count until appends are refused
        n = 0;
        while (n < RANDOM_ITEMS || appends_sent < CAPACITY + TAIL_REFUSED)
        begin
            if (n % PHASE_LEN == 0)
            begin
                wait_drained();
                case ((n / PHASE_LEN) % 4)
                    0: begin send_idle_pct = 0;  stall_pct = 0;  end
                    1: begin send_idle_pct = 51; stall_pct = 0;  end
                    2: begin send_idle_pct = 0;  stall_pct = 51; end
                    default: begin send_idle_pct = 29; stall_pct = 29; end
                endcase
            end
            filled = (appends_sent < CAPACITY) ? appends_sent : CAPACITY;
            r = $urandom_range(0, 99);
            if (filled < CAPACITY)
                kind = (r < 85) ? KIND_APPEND : (r < 93) ? KIND_READ :
                       (r < 98) ? KIND_WRITE : KIND_UNUSED;
            else
                kind = (r < 30) ? KIND_APPEND : (r < 65) ? KIND_READ :
                       (r < 95) ? KIND_WRITE : KIND_UNUSED;
            if (filled > 0 && $urandom_range(0, 1) == 1)
                idx = IDX_W'($urandom_range(0, filled - 1));
            else
                idx = IDX_W'($urandom_range(0, MAX_INDEX));
            send_request(kind, idx, VAL_W'($urandom_range(0, MAX_VALUE)));
            n++;
        end

        wait_drained();
        repeat (20) @(negedge clk);
        if (fail_count == 0)
            $display("tb: success");
        else
            $display("tb: failure");
        $finish;
    end

endmodule

[files.f]
design/pes_pkg.sv
design/pes_bank.sv
design/pes_lane.sv
design/packed_element_store.sv
dv/pes_result_checker.sv
dv/packed_element_store_tb.sv
